FILE: design/sah_pkg.sv
// Package for the statistics aggregator with histogram.
// Holds payload structs, configuration struct, queue entry and constants; no dependencies.
package sah_pkg;

   localparam int MaxBuckets = 128;
   localparam int IdxW = $clog2(MaxBuckets);
   localparam int LogZero = 64;

   typedef enum logic [1:0] {
      CSR_HIST_MODE    = 2'd0,
      CSR_BUCKET_TOTAL = 2'd1,
      CSR_RANGE_START  = 2'd2,
      CSR_BUCKET_WIDTH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_LOG    = 2'd1,
      MODE_LINEAR = 2'd2,
      MODE_SPARE  = 2'd3
   } hist_mode_type;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [63:0] sample;
      logic [6:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [6:0]         bucket_index;
      logic [63:0]        bucket_tally;
      logic [63:0]        sample_count;
      logic signed [63:0] running_sum;
      logic signed [63:0] smallest;
      logic signed [63:0] largest;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         hist_mode;
      logic [7:0]         bucket_total;
      logic signed [31:0] range_start;
      logic [30:0]        bucket_width;
   } cfg_type;

   typedef struct packed {
      logic               opcode;
      logic               hist_en;
      logic [IdxW-1:0]    index;
      logic signed [63:0] sample;
   } job_type;

endpackage

FILE: design/sah_front.sv
// Front end: accepts requests and works out the histogram bucket of each sample.
// Uses sah_pkg; feeds the job queue.
module sah_front (
   input  logic              clock,
   input  logic              reset,
   input  sah_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  sah_pkg::req_type  req_data,
   output logic              push,
   output sah_pkg::job_type  push_job,
   input  logic              q_full
);
   import sah_pkg::*;

   typedef enum logic [2:0] {F_IDLE, F_LOG, F_LIN, F_DIV, F_PUSH} fstate_type;

   fstate_type          state_ff, state_in;
   job_type             job_ff, job_in;
   logic signed [64:0]  work_ff, work_in;
   logic [5:0]          pos_ff, pos_in;
   logic [2:0]          step_ff, step_in;
   logic [6:0]          quot_ff, quot_in;
   logic                neg_ff, neg_in;
   logic [7:0]          bkt_ff, bkt_in;

   logic [30:0]         wid;
   logic [6:0]          last;
   logic [7:0]          eff;
   logic [5:0]          sh;
   logic signed [64:0]  trial;
   logic signed [64:0]  cap;
   logic [63:0]         mag;

   always_comb begin
      wid = (cfg.bucket_width == 31'd0) ? 31'd1 : cfg.bucket_width;
      if (cfg.bucket_total < 8'd3) begin
         eff = 8'd3;
      end else if (cfg.bucket_total > 8'(MaxBuckets)) begin
         eff = 8'(MaxBuckets);
      end else begin
         eff = cfg.bucket_total;
      end
      last = 7'(eff - 8'd1);
      sh = 6'd32 >> step_ff;
      trial = work_ff - (65'(wid) << step_ff);
      cap = 65'(wid) << 7;
      mag = req_data.sample[63] ? 64'(-req_data.sample) : 64'(req_data.sample);

      state_in = state_ff;
      job_in = job_ff;
      work_in = work_ff;
      pos_in = pos_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      neg_in = neg_ff;
      bkt_in = bkt_ff;

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               job_in.opcode = req_data.opcode;
               job_in.sample = req_data.sample;
               job_in.index = req_data.read_index;
               job_in.hist_en = 1'b0;
               bkt_in = {1'b0, req_data.read_index};
               state_in = F_PUSH;
               if (req_data.opcode == OP_ADD) begin
                  bkt_in = 8'd0;
                  case (hist_mode_type'(cfg.hist_mode))
                     MODE_LOG: begin
                        job_in.hist_en = 1'b1;
                        if (req_data.sample == 64'sd0) begin
                           bkt_in = 8'(LogZero);
                        end else begin
                           work_in = 65'(mag);
                           neg_in = req_data.sample[63];
                           pos_in = 6'd0;
                           step_in = 3'd0;
                           state_in = F_LOG;
                        end
                     end
                     MODE_LINEAR: begin
                        job_in.hist_en = 1'b1;
                        work_in = 65'(req_data.sample) - 65'(cfg.range_start);
                        state_in = F_LIN;
                     end
                     default: begin
                        job_in.hist_en = 1'b0;
                     end
                  endcase
               end
            end
         end
         F_LOG: begin
            if ((work_ff >>> sh) != 65'sd0) begin
               pos_in = pos_ff + sh;
               work_in = work_ff >>> sh;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               bkt_in = neg_ff ? 8'(7'd63 - {1'b0, pos_in})
                               : 8'(8'd65 + {2'b0, pos_in});
               state_in = F_PUSH;
            end
         end
         F_LIN: begin
            if (work_ff[64]) begin
               bkt_in = 8'd0;
               state_in = F_PUSH;
            end else if (work_ff >= cap) begin
               bkt_in = 8'd128;
               state_in = F_PUSH;
            end else begin
               step_in = 3'd6;
               quot_in = 7'd0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (!trial[64]) begin
               work_in = trial;
               quot_in = quot_ff | (7'd1 << step_ff);
            end
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               bkt_in = 8'(quot_in) + 8'd1;
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      push_job = job_ff;
      if (job_ff.opcode == OP_ADD) begin
         if (!job_ff.hist_en) begin
            push_job.index = '0;
         end else if (bkt_ff >= {1'b0, last}) begin
            push_job.index = last;
         end else begin
            push_job.index = bkt_ff[6:0];
         end
      end
      push = (state_ff == F_PUSH) && !q_full;
      req_stall = (state_ff != F_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff <= job_in;
      work_ff <= work_in;
      pos_ff <= pos_in;
      step_ff <= step_in;
      quot_ff <= quot_in;
      neg_ff <= neg_in;
      bkt_ff <= bkt_in;
   end

endmodule

FILE: design/sah_queue.sv
// Two-entry job queue between the front end and the back end.
// Uses sah_pkg for the job type.
module sah_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sah_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output sah_pkg::job_type  pop_job,
   output logic              empty
);
   import sah_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_job = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("Queue written while full.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("Queue read while empty.");
   a_count_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("Queue count out of range.");
`endif

endmodule

FILE: design/sah_back.sv
// Back end: tally store read-modify-write, running statistics and result register.
// Uses sah_pkg; takes jobs from the queue.
module sah_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  sah_pkg::job_type  q_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sah_pkg::rsp_type  rsp_data
);
   import sah_pkg::*;

   typedef enum logic {B_IDLE, B_RD} bstate_type;

   bstate_type          state_ff;
   logic [63:0]         mem_ff [MaxBuckets];
   logic [MaxBuckets-1:0] vld_ff;
   logic [63:0]         rd_ff;
   logic                rd_vld_ff;
   job_type             job_ff;
   logic [63:0]         count_ff;
   logic signed [63:0]  sum_ff, min_ff, max_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic [63:0]         tally;
   logic                wr;

   assign pop = (state_ff == B_IDLE) && !q_empty && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      tally = rd_vld_ff ? rd_ff : 64'd0;
      wr = (job_ff.opcode == OP_ADD) && job_ff.hist_en;
      if (wr) begin
         tally = tally + 64'd1;
      end else if (job_ff.opcode == OP_ADD) begin
         tally = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         vld_ff <= '0;
         count_ff <= 64'd0;
         sum_ff <= 64'sd0;
         min_ff <= 64'sd0;
         max_ff <= 64'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (pop) begin
                  state_ff <= B_RD;
               end
            end
            B_RD: begin
               state_ff <= B_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_ff.bucket_index <= job_ff.index;
               rsp_ff.bucket_tally <= tally;
               rsp_ff.sample_count <= count_ff;
               rsp_ff.running_sum <= sum_ff;
               rsp_ff.smallest <= min_ff;
               rsp_ff.largest <= max_ff;
               if (job_ff.opcode == OP_ADD) begin
                  count_ff <= count_ff + 64'd1;
                  rsp_ff.sample_count <= count_ff + 64'd1;
                  if (count_ff == 64'd0) begin
                     sum_ff <= job_ff.sample;
                     min_ff <= job_ff.sample;
                     max_ff <= job_ff.sample;
                     rsp_ff.running_sum <= job_ff.sample;
                     rsp_ff.smallest <= job_ff.sample;
                     rsp_ff.largest <= job_ff.sample;
                  end else begin
                     sum_ff <= sum_ff + job_ff.sample;
                     rsp_ff.running_sum <= sum_ff + job_ff.sample;
                     if (job_ff.sample < min_ff) begin
                        min_ff <= job_ff.sample;
                        rsp_ff.smallest <= job_ff.sample;
                     end
                     if (job_ff.sample > max_ff) begin
                        max_ff <= job_ff.sample;
                        rsp_ff.largest <= job_ff.sample;
                     end
                  end
               end
               if (wr) begin
                  vld_ff[job_ff.index] <= 1'b1;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
      if (pop) begin
         job_ff <= q_job;
         rd_vld_ff <= vld_ff[q_job.index];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= mem_ff[q_job.index];
      end
      if ((state_ff == B_RD) && wr) begin
         mem_ff[job_ff.index] <= tally;
      end
   end

`ifndef NO_ASSERTIONS
   a_rd_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RD) |-> !rsp_valid_ff)
      else $error("Result register busy during store access.");
   a_rd_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RD) |=> rsp_valid_ff)
      else $error("Store access did not produce a result.");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == B_RD))
      else $error("Popped job not carried out.");
`endif

endmodule

FILE: design/stat_aggregator_histogram.sv
// Top level of the statistics aggregator with histogram.
// Holds the configuration registers; uses sah_pkg, sah_front, sah_queue and sah_back.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  sah_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  sah_pkg::rsp_type
//   csr      in         csr_write            csr_index, csr_wdata
//
// A read or a non-histogram add goes straight to the push state; a log add runs a six-step
// msb search, a linear add a range check and, in range, a seven-step restoring divide. The
// back end runs tally store read, write with result load and transfer, one job at a time.
// Reset is synchronous; tallies are held valid per bucket, so no clearing pass is needed.
// A stalled result holds the back end; the queue then fills and stalls the request side.
module stat_aggregator_histogram (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sah_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sah_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import sah_pkg::*;

   cfg_type  cfg_ff;
   logic     push, pop, q_full, q_empty;
   job_type  push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hist_mode <= MODE_NONE;
         cfg_ff.bucket_total <= 8'(MaxBuckets);
         cfg_ff.range_start <= 32'sd0;
         cfg_ff.bucket_width <= 31'd1;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_HIST_MODE:    cfg_ff.hist_mode <= csr_wdata[1:0];
            CSR_BUCKET_TOTAL: cfg_ff.bucket_total <= csr_wdata[7:0];
            CSR_RANGE_START:  cfg_ff.range_start <= csr_wdata;
            CSR_BUCKET_WIDTH: cfg_ff.bucket_width <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   sah_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job),
      .q_full    (q_full)
   );

   sah_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   sah_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
